// ===== rtl/grti_pkg.sv =====
`default_nettype none

package grti_pkg;

    localparam int DATA_W    = 16;
    localparam int RATE_W    = 18;
    localparam int SUM_W     = RATE_W + 1;
    localparam int ANGLE_W   = 36;
    localparam int ACC_EXT_W = ANGLE_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 4 * DATA_W;
    localparam int OUT_TDATA_W = 112;

    localparam int QUEUE_DEPTH = 4;

    // 180 degrees in angle units
    localparam logic signed [ACC_EXT_W-1:0] HALF_TURN     = 37'sd23592960000;
    localparam logic signed [ACC_EXT_W-1:0] NEG_HALF_TURN = -37'sd23592960000;
    // 0.5 degree in angle units
    localparam logic signed [ANGLE_W-1:0]   TILT_LIMIT     = 36'sd65536000;
    localparam logic signed [ANGLE_W-1:0]   NEG_TILT_LIMIT = -36'sd65536000;

    localparam logic [DATA_W-1:0] DEADBAND_RESET = 16'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_OFFSET_Z,
        REG_DEADBAND
    } t_reg_idx;

    typedef enum logic [1:0] {
        ZONE_LEVEL,
        ZONE_ABOVE,
        ZONE_BELOW,
        ZONE_EDGE
    } t_zone;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
        logic [DATA_W-1:0]        elapsed_us;
    } t_item;

endpackage

`default_nettype wire

// ===== rtl/gyro_rate_trapezoid_integrator_core.sv =====
// channel  dir  bits  contents (lowest bit first)
// s_axis   in   64    rate_x_raw, rate_y_raw, rate_z_raw, elapsed_us
// m_axis   out  112   angle_x, angle_y, angle_z, tilt_zone_z, 2 zero bits
// cfg      in   2+16  register index, write data (no read-back)
//
// one beat per cycle unless m_axis stalls, set by the back end's accumulate-and-wrap loop
// a beat is registered in the queue, the product stage, then the accumulators
// a QUEUE_DEPTH-entry queue holds input beats until full while the output is stalled
// synchronous active-low reset clears angles, previous rates, offsets, deadband to 5
`default_nettype none

module gyro_rate_trapezoid_integrator_core #(
    parameter int QUEUE_DEPTH = grti_pkg::QUEUE_DEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // rate_x_raw[15:0], rate_y_raw[31:16], rate_z_raw[47:32], elapsed_us[63:48]
    input  wire logic [grti_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // angle_x[35:0], angle_y[71:36], angle_z[107:72], tilt_zone_z[109:108], zero[111:110]
    output logic [grti_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [grti_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [grti_pkg::DATA_W-1:0]         i_cfg_data
);

    grti_pkg::t_item                       front_item;
    grti_pkg::t_item                       head_item;
    logic                                  head_valid;
    logic                                  head_pop;
    logic signed [grti_pkg::ANGLE_W-1:0]   angle_x, angle_y, angle_z;
    grti_pkg::t_zone                       zone_z;

    grti_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tdata    (s_axis_tdata),
        .o_item     (front_item)
    );

    grti_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (front_item),
        .o_ready (s_axis_tready),
        .i_pop   (head_pop),
        .o_item  (head_item),
        .o_valid (head_valid)
    );

    grti_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (head_item),
        .i_item_valid (head_valid),
        .o_pop        (head_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_angle_x    (angle_x),
        .o_angle_y    (angle_y),
        .o_angle_z    (angle_z),
        .o_zone       (zone_z)
    );

    assign m_axis_tdata = {2'b00, zone_z, angle_z, angle_y, angle_x};

endmodule

`default_nettype wire

// ===== rtl/grti_front.sv =====
`default_nettype none

module grti_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [grti_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [grti_pkg::DATA_W-1:0]       i_cfg_data,
    input  wire logic [grti_pkg::IN_TDATA_W-1:0]   i_tdata,
    output grti_pkg::t_item                        o_item
);

    logic signed [grti_pkg::DATA_W-1:0] r_offset_x;
    logic signed [grti_pkg::DATA_W-1:0] r_offset_y;
    logic signed [grti_pkg::DATA_W-1:0] r_offset_z;
    logic [grti_pkg::DATA_W-1:0]        r_deadband;

    // raw minus offset, zeroed inside the deadband
    function automatic logic signed [grti_pkg::RATE_W-1:0] clean_rate(
        input logic [grti_pkg::DATA_W-1:0]        raw,
        input logic signed [grti_pkg::DATA_W-1:0] off,
        input logic [grti_pkg::DATA_W-1:0]        db
    );
        logic signed [grti_pkg::RATE_W-1:0] r;
        logic signed [grti_pkg::RATE_W-1:0] neg_r;
        logic [grti_pkg::DATA_W:0]          mag;
        r     = $signed({{2{raw[grti_pkg::DATA_W-1]}}, raw})
              - $signed({{2{off[grti_pkg::DATA_W-1]}}, off});
        neg_r = -r;
        mag   = r[grti_pkg::RATE_W-1] ? neg_r[grti_pkg::DATA_W:0] : r[grti_pkg::DATA_W:0];
        if (mag < {1'b0, db}) begin
            r = '0;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_offset_z <= '0;
            r_deadband <= grti_pkg::DEADBAND_RESET;
        end else if (i_cfg_we) begin
            case (grti_pkg::t_reg_idx'(i_cfg_idx))
                grti_pkg::REG_OFFSET_X: r_offset_x <= $signed(i_cfg_data);
                grti_pkg::REG_OFFSET_Y: r_offset_y <= $signed(i_cfg_data);
                grti_pkg::REG_OFFSET_Z: r_offset_z <= $signed(i_cfg_data);
                grti_pkg::REG_DEADBAND: r_deadband <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_item.rate_x     = clean_rate(i_tdata[15:0],  r_offset_x, r_deadband);
        o_item.rate_y     = clean_rate(i_tdata[31:16], r_offset_y, r_deadband);
        o_item.rate_z     = clean_rate(i_tdata[47:32], r_offset_z, r_deadband);
        o_item.elapsed_us = i_tdata[63:48];
    end

endmodule

`default_nettype wire

// ===== rtl/grti_queue.sv =====
`default_nettype none

module grti_queue #(
    parameter int DEPTH = grti_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire grti_pkg::t_item i_item,
    output logic            o_ready,
    input  wire logic       i_pop,
    output grti_pkg::t_item o_item,
    output logic            o_valid
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    grti_pkg::t_item  r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/grti_back.sv =====
`default_nettype none

module grti_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire grti_pkg::t_item                      i_item,
    input  wire logic                                 i_item_valid,
    output logic                                      o_pop,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [grti_pkg::ANGLE_W-1:0]       o_angle_x,
    output logic signed [grti_pkg::ANGLE_W-1:0]       o_angle_y,
    output logic signed [grti_pkg::ANGLE_W-1:0]       o_angle_z,
    output grti_pkg::t_zone                           o_zone
);

    // product stage
    logic                                   r_a_valid;
    logic signed [grti_pkg::ANGLE_W-1:0]    r_prod_x, r_prod_y, r_prod_z;
    logic signed [grti_pkg::RATE_W-1:0]     r_prev_x, r_prev_y, r_prev_z;
    // accumulators double as the output register
    logic                                   r_out_valid;
    logic signed [grti_pkg::ANGLE_W-1:0]    r_acc_x, r_acc_y, r_acc_z;

    logic signed [grti_pkg::ANGLE_W-1:0]    n_prod_x, n_prod_y, n_prod_z;
    logic signed [grti_pkg::ANGLE_W-1:0]    n_acc_x, n_acc_y, n_acc_z;
    logic                                   out_free;
    logic                                   a_free;
    logic                                   a_move;

    // (rate + prev) * elapsed, exact in 36 bits
    function automatic logic signed [grti_pkg::ANGLE_W-1:0] trap_step(
        input logic signed [grti_pkg::RATE_W-1:0] prev,
        input logic signed [grti_pkg::RATE_W-1:0] rate,
        input logic [grti_pkg::DATA_W-1:0]        dt
    );
        logic signed [grti_pkg::SUM_W-1:0]    sum;
        logic signed [grti_pkg::DATA_W:0]     dt_s;
        logic signed [grti_pkg::ANGLE_W-1:0]  sum_w;
        logic signed [grti_pkg::ANGLE_W-1:0]  dt_w;
        sum   = $signed({prev[grti_pkg::RATE_W-1], prev})
              + $signed({rate[grti_pkg::RATE_W-1], rate});
        dt_s  = $signed({1'b0, dt});
        sum_w = grti_pkg::ANGLE_W'(sum);
        dt_w  = grti_pkg::ANGLE_W'(dt_s);
        return sum_w * dt_w;
    endfunction

    // add and fold once into the open half-turn range, sign kept
    function automatic logic signed [grti_pkg::ANGLE_W-1:0] wrap_add(
        input logic signed [grti_pkg::ANGLE_W-1:0] acc,
        input logic signed [grti_pkg::ANGLE_W-1:0] prod
    );
        logic signed [grti_pkg::ACC_EXT_W-1:0] s;
        s = grti_pkg::ACC_EXT_W'(acc) + grti_pkg::ACC_EXT_W'(prod);
        if (s >= grti_pkg::HALF_TURN) begin
            s = s - grti_pkg::HALF_TURN;
        end else if (s <= grti_pkg::NEG_HALF_TURN) begin
            s = s + grti_pkg::HALF_TURN;
        end
        return s[grti_pkg::ANGLE_W-1:0];
    endfunction

    assign out_free = !r_out_valid || i_out_ready;
    assign a_free   = !r_a_valid || out_free;
    assign a_move   = r_a_valid && out_free;
    assign o_pop    = i_item_valid && a_free;

    always_comb begin
        n_prod_x = trap_step(r_prev_x, i_item.rate_x, i_item.elapsed_us);
        n_prod_y = trap_step(r_prev_y, i_item.rate_y, i_item.elapsed_us);
        n_prod_z = trap_step(r_prev_z, i_item.rate_z, i_item.elapsed_us);
        n_acc_x  = wrap_add(r_acc_x, r_prod_x);
        n_acc_y  = wrap_add(r_acc_y, r_prod_y);
        n_acc_z  = wrap_add(r_acc_z, r_prod_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_out_valid <= 1'b0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_z     <= '0;
        end else begin
            if (o_pop) begin
                r_a_valid <= 1'b1;
                r_prev_x  <= i_item.rate_x;
                r_prev_y  <= i_item.rate_y;
                r_prev_z  <= i_item.rate_z;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_out_valid <= 1'b1;
                r_acc_x     <= n_acc_x;
                r_acc_y     <= n_acc_y;
                r_acc_z     <= n_acc_z;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
        end
    end

    always_comb begin
        if (r_acc_z > grti_pkg::TILT_LIMIT) begin
            o_zone = grti_pkg::ZONE_ABOVE;
        end else if (r_acc_z < grti_pkg::NEG_TILT_LIMIT) begin
            o_zone = grti_pkg::ZONE_BELOW;
        end else if (r_acc_z == grti_pkg::TILT_LIMIT || r_acc_z == grti_pkg::NEG_TILT_LIMIT) begin
            o_zone = grti_pkg::ZONE_EDGE;
        end else begin
            o_zone = grti_pkg::ZONE_LEVEL;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_angle_x   = r_acc_x;
    assign o_angle_y   = r_acc_y;
    assign o_angle_z   = r_acc_z;

`ifndef ASSERT_OFF
    a_acc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (grti_pkg::ACC_EXT_W'(r_acc_z) < grti_pkg::HALF_TURN)
        && (grti_pkg::ACC_EXT_W'(r_acc_z) > grti_pkg::NEG_HALF_TURN))
        else $error("z accumulator left the half-turn range");

    a_prev_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_prev_x == $past(i_item.rate_x)) && r_a_valid)
        else $error("previous rate not taken from popped beat");

    a_acc_holds_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_acc_x) && $stable(r_acc_z))
        else $error("accumulator changed while result stalled");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_move |=> r_out_valid)
        else $error("product stage drained without a result");
`endif

endmodule

`default_nettype wire
